/* rtl/tufe_pkg.sv */
// Shared types and constants for the treadmill serial frame extractor.
`timescale 1ns / 1ps

package tufe_pkg;

  // Default byte window depth; the framing rules never hold more than 18 bytes.
  localparam int unsigned STORE_DEPTH_DEF = 32;

  // Depth of the event queue between the frame sequencer and the output stage.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_STOP = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_ERR  = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  key_value;
    logic [3:0]  key_index;
    logic [3:0]  key_length;
    logic        last_of_run;
  } event_t;

endpackage

/* rtl/treadmill_uart_frame_extractor.sv */
// Top level of the treadmill serial frame extractor.
// Bytes are taken one per cycle while the sequencer is idle; once 15 are buffered,
//   rx_stall_o holds the input through the header search, classification and packet drop,
//   which sheds one byte per cycle except while a key byte waits on a full event queue.
// Reset (rst_ni low, asynchronous): sequencer, fill count, queue and counters clear.
`timescale 1ns / 1ps

module treadmill_uart_frame_extractor #(
  parameter int unsigned STORE_DEPTH = tufe_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result transfers
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  key_value_o,
  output logic [3:0]  key_index_o,
  output logic [3:0]  key_length_o,
  output logic        last_of_run_o,
  output logic [31:0] packets_seen_o,
  output logic [31:0] errors_seen_o
);

  // Front: byte window (a shift line, slot 0 is the oldest byte) plus the sequencer
  // that finds the header, applies the trailer rules and streams key bytes out.
  // Window data is not reset; only the first fill-count slots are ever looked at.
  tufe_pkg::event_t push_data, pop_data;
  logic             push, full, pop, empty;

  tufe_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .ev_push_o  (push),
    .ev_data_o  (push_data),
    .ev_full_i  (full)
  );

  // Queue decouples the sequencer from a stalled consumer; the front only
  // waits on it when it actually has an event to push.
  tufe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  // Back: output register; the running counters advance as each event is loaded,
  // so every transfer carries the counts after its own event.
  tufe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_data_i      (pop_data),
    .ev_empty_i     (empty),
    .ev_pop_o       (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .key_value_o    (key_value_o),
    .key_index_o    (key_index_o),
    .key_length_o   (key_length_o),
    .last_of_run_o  (last_of_run_o),
    .packets_seen_o (packets_seen_o),
    .errors_seen_o  (errors_seen_o)
  );

endmodule

/* rtl/tufe_front.sv */
// Byte window, header search and packet classification sequencer.
`timescale 1ns / 1ps

module tufe_front #(
  parameter int unsigned STORE_DEPTH = tufe_pkg::STORE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_stall_o,
  input  logic [7:0]       rx_byte_i,
  output logic             ev_push_o,
  output tufe_pkg::event_t ev_data_o,
  input  logic             ev_full_i
);

  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);

  localparam logic [FILL_W-1:0] FILL_HDR  = FILL_W'(4);
  localparam logic [FILL_W-1:0] FILL_SCAN = FILL_W'(15);
  localparam logic [FILL_W-1:0] FILL_16   = FILL_W'(16);
  localparam logic [FILL_W-1:0] FILL_17   = FILL_W'(17);
  localparam logic [FILL_W-1:0] FILL_18   = FILL_W'(18);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STORE_DEPTH);

  localparam logic [4:0] LEN_STOP = 5'd15;
  localparam logic [4:0] LEN_16   = 5'd16;
  localparam logic [4:0] LEN_17   = 5'd17;
  localparam logic [4:0] LEN_18   = 5'd18;
  localparam logic [4:0] KST_16   = 5'd10;
  localparam logic [4:0] KST_17   = 5'd8;
  localparam logic [4:0] KST_18   = 5'd12;
  localparam logic [3:0] KLEN_6   = 4'd6;
  localparam logic [3:0] KLEN_9   = 4'd9;

  localparam logic [7:0] HDR0      = 8'h80;
  localparam logic [7:0] HDR1      = 8'h1E;
  localparam logic [7:0] HDR2      = 8'h80;
  localparam logic [7:0] HDR3      = 8'h00;
  localparam logic [7:0] STOP_MARK = 8'h00;
  localparam logic [7:0] TRAILER   = 8'hF8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_CLASS  = 4'b0100,
    S_DROP   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        win_q [STORE_DEPTH];
  logic [7:0]        win_d [STORE_DEPTH];
  logic [7:0]        shift_src [STORE_DEPTH];
  logic [4:0]        plen_q, plen_d;
  logic [4:0]        kstart_q, kstart_d;
  logic [3:0]        klen_q, klen_d;
  logic [4:0]        pos_q, pos_d;
  logic              speed_q, speed_d;

  logic       shift, append, hdr_hit, stopped, cls_wait, key_pos, last_pos;
  logic [4:0] cls_plen, cls_kstart;
  logic [3:0] cls_klen;

  assign hdr_hit = (win_q[0] == HDR0) && (win_q[1] == HDR1) &&
                   (win_q[2] == HDR2) && (win_q[3] == HDR3);
  assign stopped  = (win_q[4] == STOP_MARK);
  assign key_pos  = speed_q && (pos_q >= kstart_q);
  assign last_pos = (pos_q == plen_q - 5'd1);

  // Frame end rules, all on fixed window offsets; a zero length means no trailer.
  always_comb begin
    cls_plen   = '0;
    cls_kstart = '0;
    cls_klen   = '0;
    cls_wait   = 1'b0;
    if (stopped) begin
      if (win_q[14] == TRAILER) begin
        cls_plen = LEN_STOP;
      end
    end else if ((fill_q >= FILL_18) && (win_q[17] == TRAILER)) begin
      cls_plen   = LEN_18;
      cls_kstart = KST_18;
      cls_klen   = KLEN_6;
    end else if ((fill_q >= FILL_17) && (win_q[16] == TRAILER)) begin
      cls_plen   = LEN_17;
      cls_kstart = KST_17;
      cls_klen   = KLEN_9;
    end else if ((fill_q >= FILL_16) && (win_q[15] == TRAILER)) begin
      cls_plen   = LEN_16;
      cls_kstart = KST_16;
      cls_klen   = KLEN_6;
    end else if (fill_q < FILL_18) begin
      cls_wait = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    plen_d    = plen_q;
    kstart_d  = kstart_q;
    klen_d    = klen_q;
    pos_d     = pos_q;
    speed_d   = speed_q;
    shift     = 1'b0;
    append    = 1'b0;
    ev_push_o = 1'b0;
    ev_data_o = '{kind: tufe_pkg::KIND_STOP, key_value: 8'd0, key_index: 4'd0,
                  key_length: 4'd0, last_of_run: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (rx_valid_i) begin
          append = (fill_q < FILL_FULL);
          if (append) begin
            fill_d = fill_q + 1'b1;
          end
          if (fill_d >= FILL_SCAN) begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // one offset per cycle; without a header the window ends at three bytes
        if (fill_q < FILL_HDR) begin
          state_d = S_IDLE;
        end else if (hdr_hit) begin
          state_d = S_CLASS;
        end else begin
          shift = 1'b1;
        end
      end
      S_CLASS: begin
        if ((fill_q < FILL_SCAN) || cls_wait) begin
          state_d = S_IDLE;
        end else if (cls_plen == '0) begin
          ev_data_o.kind        = tufe_pkg::KIND_ERR;
          ev_data_o.last_of_run = 1'b1;
          if (!ev_full_i) begin
            ev_push_o = 1'b1;
            shift     = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          ev_data_o.kind        = tufe_pkg::KIND_STOP;
          ev_data_o.last_of_run = 1'b1;
          if (!(stopped && ev_full_i)) begin
            ev_push_o = stopped;
            plen_d    = cls_plen;
            kstart_d  = cls_kstart;
            klen_d    = cls_klen;
            speed_d   = !stopped;
            pos_d     = '0;
            state_d   = S_DROP;
          end
        end
      end
      S_DROP: begin
        // packet leaves through window slot 0; key bytes are tapped on the way
        ev_data_o.kind        = tufe_pkg::KIND_KEY;
        ev_data_o.key_value   = win_q[0];
        ev_data_o.key_index   = 4'(pos_q - kstart_q);
        ev_data_o.key_length  = klen_q;
        ev_data_o.last_of_run = last_pos;
        if (!(key_pos && ev_full_i)) begin
          ev_push_o = key_pos;
          shift     = 1'b1;
          pos_d     = pos_q + 5'd1;
          if (last_pos) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (shift) begin
      fill_d = fill_q - 1'b1;
    end
  end

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_win
    if (g < STORE_DEPTH - 1) begin : g_mid
      assign shift_src[g] = win_q[g+1];
    end else begin : g_end
      assign shift_src[g] = win_q[g];
    end
    assign win_d[g] = shift ? shift_src[g] :
                      (append && (fill_q[IDX_W-1:0] == IDX_W'(g))) ? rx_byte_i : win_q[g];
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      plen_q   <= '0;
      kstart_q <= '0;
      klen_q   <= '0;
      pos_q    <= '0;
      speed_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      plen_q   <= plen_d;
      kstart_q <= kstart_d;
      klen_q   <= klen_d;
      pos_q    <= pos_d;
      speed_q  <= speed_d;
    end
  end

  assign rx_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_idle_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (fill_q < FILL_18))
    else $error("window holds more than 17 bytes between bytes");

  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push_o |-> ((state_q == S_CLASS) || (state_q == S_DROP)))
    else $error("event pushed outside classification or drop");
`endif

endmodule

/* rtl/tufe_fifo.sv */
// Small event queue between the frame sequencer and the output stage.
`timescale 1ns / 1ps

module tufe_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tufe_pkg::event_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output tufe_pkg::event_t data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(tufe_pkg::QUEUE_DEPTH);

  tufe_pkg::event_t mem_q [tufe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(tufe_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event pushed into a full queue");
`endif

endmodule

/* rtl/tufe_back.sv */
// Output register with packet and error counters.
`timescale 1ns / 1ps

module tufe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tufe_pkg::event_t ev_data_i,
  input  logic             ev_empty_i,
  output logic             ev_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       event_kind_o,
  output logic [7:0]       key_value_o,
  output logic [3:0]       key_index_o,
  output logic [3:0]       key_length_o,
  output logic             last_of_run_o,
  output logic [31:0]      packets_seen_o,
  output logic [31:0]      errors_seen_o
);

  tufe_pkg::event_t ev_q, ev_d;
  logic             valid_q, valid_d;
  logic [31:0]      pkt_q, pkt_d;
  logic [31:0]      err_q, err_d;
  logic             load;

  assign load     = !ev_empty_i && (!valid_q || !out_stall_i);
  assign ev_pop_o = load;

  always_comb begin
    valid_d = load || (valid_q && out_stall_i);
    ev_d    = load ? ev_data_i : ev_q;
    pkt_d   = pkt_q;
    err_d   = err_q;
    if (load) begin
      // a packet counts once: on its stop event or on its first key byte
      if ((ev_data_i.kind == tufe_pkg::KIND_STOP) ||
          ((ev_data_i.kind == tufe_pkg::KIND_KEY) && (ev_data_i.key_index == 4'd0))) begin
        pkt_d = pkt_q + 32'd1;
      end
      if (ev_data_i.kind == tufe_pkg::KIND_ERR) begin
        err_d = err_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q   <= '0;
      err_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pkt_q   <= pkt_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign event_kind_o   = ev_q.kind;
  assign key_value_o    = ev_q.key_value;
  assign key_index_o    = ev_q.key_index;
  assign key_length_o   = ev_q.key_length;
  assign last_of_run_o  = ev_q.last_of_run;
  assign packets_seen_o = pkt_q;
  assign errors_seen_o  = err_q;

`ifndef SYNTHESIS
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (ev_data_i.kind == tufe_pkg::KIND_ERR)) |=> (err_q == $past(err_q) + 32'd1))
    else $error("error counter missed a framing error");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> ($stable(pkt_q) && $stable(err_q)))
    else $error("counter moved without an event");
`endif

endmodule
